/* sv/dice_sum_count_matrix_power_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the die-sum counter
// Shared helpers for concurrent checks on i_clk, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef DICE_SUM_COUNT_MATRIX_POWER_DEFINES_SVH
`define DICE_SUM_COUNT_MATRIX_POWER_DEFINES_SVH

// Same-cycle implication.
`define DSCMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dscmp: check failed");

// Next-cycle implication.
`define DSCMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dscmp: check failed");

`endif

/* sv/dscmp_pkg.sv */
// ----------------------------------------------------------------------------
// Die-sum counter package
// Shared constants, element types and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package dscmp_pkg;

    localparam int ExpBits = 60;
    localparam int Order   = 6;
    localparam int ElemW   = 30;
    localparam int IdxW    = $clog2(Order);

    localparam logic [ElemW-1:0] Modulus = 30'd1000000007;

    typedef logic [ElemW-1:0] t_elem;
    typedef logic [IdxW-1:0]  t_idx;

    // One operand fetch for the multiply-accumulate unit.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic square;
        t_idx i;
        t_idx j;
        t_idx k;
    } t_rd_req;

    // Tag that travels with a product down the pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic square;
        t_idx i;
        t_idx j;
    } t_tag;

    typedef struct packed {
        t_tag  tag;
        t_elem a;
        t_elem b;
    } t_mac_op;

    typedef struct packed {
        logic  vld;
        logic  square;
        t_idx  i;
        t_idx  j;
        t_elem data;
    } t_mac_res;

    typedef struct packed {
        logic clear;
        logic commit;
        logic to_base;
    } t_mat_ctl;

endpackage

/* sv/dscmp_if.sv */
// ----------------------------------------------------------------------------
// Die-sum counter channels
// Valid/ready channels for the exponent input and the count output.
// ----------------------------------------------------------------------------
interface dscmp_exp_if;
    import dscmp_pkg::*;

    logic               valid;
    logic               ready;
    logic [ExpBits-1:0] exponent;

    modport source (output valid, output exponent, input ready);
    modport sink   (input valid, input exponent, output ready);
endinterface

interface dscmp_cnt_if;
    import dscmp_pkg::*;

    logic             valid;
    logic             ready;
    logic [ElemW-1:0] count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

/* sv/dscmp_mac.sv */
// ----------------------------------------------------------------------------
// Modular multiply-accumulate unit
// Pipelined a*b mod p with Barrett reduction, summed over one dot product.
// ----------------------------------------------------------------------------
`include "dice_sum_count_matrix_power_defines.svh"

module dscmp_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dscmp_pkg::t_mac_op  i_op,
    output dscmp_pkg::t_mac_res o_res
);
    import dscmp_pkg::*;

    localparam int ProdW = 2 * ElemW;
    localparam int TW    = ProdW + 2;
    localparam int RW    = ElemW + 2;
    localparam logic [ElemW:0] BarrettMu =
        (ElemW+1)'((64'd1 << ProdW) / 64'(Modulus));
    localparam logic [RW-1:0] ModR  = RW'(Modulus);
    localparam logic [RW-1:0] Mod2R = RW'(Modulus) << 1;

    t_tag             r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag;
    logic [ProdW-1:0] r_s1_x;
    logic [TW-1:0]    r_s2_t;
    logic [RW-1:0]    r_s2_xl, r_s3_xl, r_s3_qp;
    t_elem            r_s4_r;
    t_elem            r_acc;
    t_mac_res         r_res;

    logic [ElemW-1:0] w_q;
    logic [RW-1:0]    w_d, w_d1, w_d2;
    t_elem            n_s4_r;
    logic [ElemW:0]   w_sum;
    t_elem            n_sum;

    assign w_q = r_s2_t[ProdW:ElemW+1];

    always_comb begin
        w_d  = r_s3_xl - r_s3_qp;
        w_d1 = w_d - ModR;
        w_d2 = w_d - Mod2R;
        if (w_d >= Mod2R) begin
            n_s4_r = w_d2[ElemW-1:0];
        end else if (w_d >= ModR) begin
            n_s4_r = w_d1[ElemW-1:0];
        end else begin
            n_s4_r = w_d[ElemW-1:0];
        end
    end

    always_comb begin
        w_sum = {1'b0, (r_s4_tag.first ? t_elem'(0) : r_acc)} + {1'b0, r_s4_r};
        if (w_sum >= {1'b0, Modulus}) begin
            n_sum = ElemW'(w_sum - {1'b0, Modulus});
        end else begin
            n_sum = w_sum[ElemW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag  <= '0;
            r_s2_tag  <= '0;
            r_s3_tag  <= '0;
            r_s4_tag  <= '0;
            r_res.vld <= 1'b0;
        end else begin
            r_s1_tag  <= i_op.tag;
            r_s2_tag  <= r_s1_tag;
            r_s3_tag  <= r_s2_tag;
            r_s4_tag  <= r_s3_tag;
            r_res.vld <= r_s4_tag.vld && r_s4_tag.last;
        end
        r_s1_x  <= ProdW'(i_op.a) * ProdW'(i_op.b);
        r_s2_t  <= TW'(r_s1_x[ProdW-1:ElemW-1]) * TW'(BarrettMu);
        r_s2_xl <= r_s1_x[RW-1:0];
        r_s3_qp <= RW'(w_q) * ModR;
        r_s3_xl <= r_s2_xl;
        r_s4_r  <= n_s4_r;
        if (r_s4_tag.vld) begin
            r_acc <= n_sum;
        end
        r_res.square <= r_s4_tag.square;
        r_res.i      <= r_s4_tag.i;
        r_res.j      <= r_s4_tag.j;
        r_res.data   <= n_sum;
    end

    assign o_res = r_res;

    `DSCMP_ASSERT_IMP(a_res_reduced, r_res.vld, r_res.data < Modulus)

endmodule

/* sv/dscmp_mats.sv */
// ----------------------------------------------------------------------------
// Matrix store
// Double-banked memories for the running power and the squared base, with
// the identity and companion start values supplied until first committed.
// ----------------------------------------------------------------------------
module dscmp_mats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dscmp_pkg::t_rd_req  i_rd,
    input  dscmp_pkg::t_mac_res i_wr,
    input  dscmp_pkg::t_mat_ctl i_ctl,
    output dscmp_pkg::t_mac_op  o_op
);
    import dscmp_pkg::*;

    localparam int   AddrW   = 1 + 2 * IdxW;
    localparam int   Depth   = 2 ** AddrW;
    localparam t_idx LastIdx = t_idx'(Order - 1);

    function automatic t_elem f_ident(t_idx r, t_idx c);
        return (r == c) ? t_elem'(1) : '0;
    endfunction

    function automatic t_elem f_comp(t_idx r, t_idx c);
        if (r == LastIdx) begin
            return t_elem'(1);
        end
        return (c == t_idx'(r + t_idx'(1))) ? t_elem'(1) : '0;
    endfunction

    t_elem r_acc_mem  [Depth];
    t_elem r_base_mem [Depth];

    logic  r_acc_bank, r_base_bank;
    logic  r_acc_pri, r_base_pri;
    t_elem r_acc_q, r_base_qa, r_base_qb;
    t_tag  r_tag;
    t_idx  r_k;

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            if (i_wr.square) begin
                r_base_mem[{~r_base_bank, i_wr.i, i_wr.j}] <= i_wr.data;
            end else begin
                r_acc_mem[{~r_acc_bank, i_wr.i, i_wr.j}] <= i_wr.data;
            end
        end
        r_acc_q   <= r_acc_mem[{r_acc_bank, i_rd.i, i_rd.k}];
        r_base_qa <= r_base_mem[{r_base_bank, i_rd.i, i_rd.k}];
        r_base_qb <= r_base_mem[{r_base_bank, i_rd.k, i_rd.j}];
        r_k       <= i_rd.k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_bank  <= 1'b0;
            r_base_bank <= 1'b0;
            r_acc_pri   <= 1'b1;
            r_base_pri  <= 1'b1;
            r_tag       <= '0;
        end else begin
            r_tag.vld    <= i_rd.vld;
            r_tag.first  <= i_rd.first;
            r_tag.last   <= i_rd.last;
            r_tag.square <= i_rd.square;
            r_tag.i      <= i_rd.i;
            r_tag.j      <= i_rd.j;
            if (i_ctl.clear) begin
                r_acc_pri  <= 1'b1;
                r_base_pri <= 1'b1;
            end else if (i_ctl.commit) begin
                // The finished product sits in the other bank; make it current.
                if (i_ctl.to_base) begin
                    r_base_bank <= ~r_base_bank;
                    r_base_pri  <= 1'b0;
                end else begin
                    r_acc_bank <= ~r_acc_bank;
                    r_acc_pri  <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_op.tag = r_tag;
        if (r_tag.square) begin
            o_op.a = r_base_pri ? f_comp(r_tag.i, r_k) : r_base_qa;
        end else begin
            o_op.a = r_acc_pri ? f_ident(r_tag.i, r_k) : r_acc_q;
        end
        o_op.b = r_base_pri ? f_comp(r_k, r_tag.j) : r_base_qb;
    end

endmodule

/* sv/dice_sum_count_matrix_power.sv */
// ----------------------------------------------------------------------------
// Die-sum counter by matrix power
// Counts ordered die-throw sequences summing to n, modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage:
// An exponent beat on i_exp starts one calculation; i_exp.ready is high only
// while the sequencer is idle. The count leaves on o_cnt as one beat, held in
// an output register, so the next exponent may be taken while that beat
// still waits for the receiver.
// The power of the 6x6 companion matrix is built by square-and-multiply,
// low exponent bit first, stopping once no set bits remain. Every matrix
// product runs its 216 element products through the one modular
// multiply-accumulate pipeline, one per cycle, followed by a drain in
// S_DRAIN before the product is committed. An exponent of up to 60 bits,
// of bit length L with s set bits, takes (L - 1 + s) products; an
// exponent of zero takes none.
// Reset returns the sequencer to idle and empties the output register; the
// matrix memories need no clearing. If the receiver stalls, a finished count
// waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`include "dice_sum_count_matrix_power_defines.svh"

module dice_sum_count_matrix_power (
    input logic          i_clk,
    input logic          i_rst_n,
    dscmp_exp_if.sink    i_exp,
    dscmp_cnt_if.source  o_cnt
);
    import dscmp_pkg::*;

    localparam int   DrainCycles = 8;
    localparam int   DrainW      = $clog2(DrainCycles);
    localparam t_idx LastIdx     = t_idx'(Order - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_DRAIN,
        S_RD,
        S_CAP
    } t_state;

    t_state             r_state, n_state;
    logic [ExpBits-1:0] r_exp, n_exp;
    logic               r_square, n_square;
    t_idx               r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DrainW-1:0]  r_drain, n_drain;
    logic               r_out_vld, n_out_vld;
    t_elem              r_count, n_count;

    t_rd_req  w_req;
    t_mat_ctl w_ctl;
    t_mac_op  w_op;
    t_mac_res w_res;

    dscmp_mats u_mats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_req),
        .i_wr    (w_res),
        .i_ctl   (w_ctl),
        .o_op    (w_op)
    );

    dscmp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_res   (w_res)
    );

    assign i_exp.ready = (r_state == S_IDLE);
    assign o_cnt.valid = r_out_vld;
    assign o_cnt.count = r_count;

    always_comb begin
        n_state   = r_state;
        n_exp     = r_exp;
        n_square  = r_square;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_drain   = r_drain;
        n_out_vld = r_out_vld;
        n_count   = r_count;
        w_req     = '0;
        w_ctl     = '0;

        if (o_cnt.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_exp.valid) begin
                    n_exp     = i_exp.exponent;
                    w_ctl.clear = 1'b1;
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (r_exp == '0) begin
                    n_state = S_RD;
                end else if (r_exp[0]) begin
                    // Fold the base into the running power, then square next.
                    n_square = 1'b0;
                    n_exp    = r_exp & ~ExpBits'(1);
                    n_state  = S_MUL;
                end else begin
                    n_square = 1'b1;
                    n_exp    = r_exp >> 1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                w_req.vld    = 1'b1;
                w_req.first  = (r_k == '0);
                w_req.last   = (r_k == LastIdx);
                w_req.square = r_square;
                w_req.i      = r_i;
                w_req.j      = r_j;
                w_req.k      = r_k;
                if (r_k == LastIdx) begin
                    n_k = '0;
                    if (r_j == LastIdx) begin
                        n_j = '0;
                        if (r_i == LastIdx) begin
                            n_drain = DrainW'(DrainCycles - 1);
                            n_state = S_DRAIN;
                        end else begin
                            n_i = t_idx'(r_i + t_idx'(1));
                        end
                    end else begin
                        n_j = t_idx'(r_j + t_idx'(1));
                    end
                end else begin
                    n_k = t_idx'(r_k + t_idx'(1));
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    w_ctl.commit  = 1'b1;
                    w_ctl.to_base = r_square;
                    n_state       = S_STEP;
                end else begin
                    n_drain = DrainW'(r_drain - 1'b1);
                end
            end
            S_RD: begin
                w_req.i = LastIdx;
                w_req.k = LastIdx;
                n_state = S_CAP;
            end
            S_CAP: begin
                // Keep reading the corner entry so it stays valid while stalled.
                w_req.i = LastIdx;
                w_req.k = LastIdx;
                if (!r_out_vld || o_cnt.ready) begin
                    n_out_vld = 1'b1;
                    n_count   = w_op.a;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_square  <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_drain   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_square  <= n_square;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_drain   <= n_drain;
            r_out_vld <= n_out_vld;
        end
        r_exp   <= n_exp;
        r_count <= n_count;
    end

    `DSCMP_ASSERT_NXT(a_one_item_at_a_time, i_exp.valid && i_exp.ready, !i_exp.ready)
    `DSCMP_ASSERT_IMP(a_result_in_product, w_res.vld, r_state == S_MUL || r_state == S_DRAIN)
    `DSCMP_ASSERT_IMP(a_count_reduced, r_out_vld, r_count < Modulus)
    `DSCMP_ASSERT_IMP(a_k_in_range, r_state == S_MUL, r_k <= LastIdx)

endmodule
